FILE: src/rgli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgli_pkg
// Shared types and constants for the rectilinear grid locator.
// ----------------------------------------------------------------------------
package rgli_pkg;
	localparam int MAX_AXES_DEF    = 3;
	localparam int MAX_COORDS_DEF  = 256;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int IDX_W           = 24;
	localparam int WGT_W           = 17;
	localparam int FRAC_W          = 16;
	localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_LOCATE = 2'd1,
		OP_INTERP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_AXIS_COUNT = 2'd0,
		REG_SIZE0      = 2'd1,
		REG_SIZE1      = 2'd2,
		REG_SIZE2      = 2'd3
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_LO_RD,
		ST_LO_WAIT,
		ST_UP_WAIT,
		ST_DIV,
		ST_AXIS_END,
		ST_CORNER,
		ST_CMUL1,
		ST_CMUL2,
		ST_EMIT
	} state_t;
endpackage
`default_nettype wire

FILE: src/rgli_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgli_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module rgli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: src/rgli_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgli_div
// Restoring divider for the cell fraction, one quotient bit per cycle,
// rounded to nearest with ties up. The numerator is below the denominator.
// ----------------------------------------------------------------------------
module rgli_div #(
	parameter int W = 33
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [W-1:0]                  num,
	input  wire logic [W-1:0]                  den,
	output logic                               done,
	output logic      [rgli_pkg::FRAC_W:0]     quot
);
	import rgli_pkg::*;
	localparam int CW = $clog2(FRAC_W + 2);

	logic [W-1:0]      rem_q;
	logic [W-1:0]      den_q;
	logic [FRAC_W:0]   q_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [W:0]        trial;

	assign trial = {rem_q, 1'b0} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(FRAC_W)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// 17 steps: 16 quotient bits plus one rounding bit (ties up)
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				q_q   <= {q_q[FRAC_W-1:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], 1'b0};
				q_q   <= {q_q[FRAC_W-1:0], 1'b0};
			end
		end
	end

	assign quot = (q_q >> 1) + {{FRAC_W{1'b0}}, q_q[0]};
endmodule
`default_nettype wire

FILE: src/rectilinear_grid_locate_interp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rectilinear_grid_locate_interp
// Per-axis coordinate tables, cell locate and multilinear corner weights.
// ----------------------------------------------------------------------------
// One item at a time. A load or an ignored opcode is handled in ST_IDLE. A
// query runs a binary search per axis over the shared table RAM, each probe
// a read (ST_SRCH_RD) and a compare (ST_SRCH_CMP), and a last ST_SRCH_RD to
// finish, with up to 9 probes for 256 entries. A locate then passes ST_LO_RD
// and closes the axis in ST_AXIS_END. An interpolation reads the two
// bracketing entries (ST_LO_RD, ST_LO_WAIT, ST_UP_WAIT), runs the divider
// when the fraction is strictly inside the cell, and closes the axis in
// ST_AXIS_END. Every result then passes ST_CORNER, ST_CMUL1 once per axis and
// ST_CMUL2 through one shared 33x17 multiplier that keeps the exact weight
// product and rounds once, and waits in ST_EMIT while the output stalls.
// Results wait in an output register.
module rectilinear_grid_locate_interp #(
	parameter int MAX_AXES    = rgli_pkg::MAX_AXES_DEF,
	parameter int MAX_COORDS  = rgli_pkg::MAX_COORDS_DEF,
	parameter int COORD_WIDTH = rgli_pkg::COORD_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[1:0], axis_sel[3:2], entry_index[11:4], coord_value[43:12],
	// point_x[75:44], point_y[107:76], point_z[139:108]
	input  wire logic [143:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// flat_index[23:0], weight[40:24]
	output logic [47:0]      m_tdata,
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);
	import rgli_pkg::*;

	localparam int EW    = $clog2(MAX_COORDS);
	localparam int DEP   = MAX_AXES * MAX_COORDS;
	localparam int RW    = $clog2(DEP);
	localparam int CW    = COORD_WIDTH;
	localparam int SW    = EW + 1;
	localparam int INW   = (CW < 32) ? CW : 32;
	localparam int ACC_W = 3 * FRAC_W + 1;

	logic [1:0]    axis_cnt_q;
	logic [8:0]    size_q [3];
	state_t        state_q, state_d;

	logic [1:0]    op_q;
	logic [CW-1:0] pt_q [3];
	logic [1:0]    ax_q;
	logic [1:0]    na_q;
	logic [SW-1:0] lo_b_q, hi_b_q;
	logic [EW-1:0] up_q [3];
	logic [EW-1:0] lo_q [3];
	logic [FRAC_W:0] wu_q [3];
	logic [CW-1:0] clo_q;
	logic [IDX_W-1:0] fac_q [3];
	logic [IDX_W-1:0] f_q;
	logic [3:0]    corner_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] cprod;
	logic [IDX_W-1:0] flat_q;
	logic [SW-1:0] n_cur;
	logic [SW-1:0] mid;
	logic [RW-1:0] raddr;
	logic [CW-1:0] rdata;
	logic          ram_we;
	logic [RW-1:0] waddr;
	logic [CW-1:0] wval;
	logic          div_start, div_done;
	logic [FRAC_W:0] div_q;
	logic [CW:0]   span, offs;
	logic          out_full_q;
	logic [IDX_W-1:0] o_flat_q;
	logic [WGT_W-1:0] o_w_q;
	logic          o_last_q;
	logic          accept;
	logic [1:0]    na_in;

	// --- configuration ---
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_cnt_q <= 2'd3;
			size_q[0]  <= 9'd1;
			size_q[1]  <= 9'd1;
			size_q[2]  <= 9'd1;
		end else if (cfg_valid) begin
			unique case (reg_t'(cfg_index))
				REG_AXIS_COUNT: axis_cnt_q <= cfg_data[1:0];
				REG_SIZE0:      size_q[0] <= cfg_data;
				REG_SIZE1:      size_q[1] <= cfg_data;
				REG_SIZE2:      size_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [SW-1:0] eff_size(input logic [8:0] s);
		logic [SW-1:0] r;
		if (s == 9'd0) r = SW'(1);
		else if (32'(s) > MAX_COORDS) r = SW'(MAX_COORDS);
		else r = SW'(s);
		return r;
	endfunction

	assign na_in = (axis_cnt_q == 2'd0) ? 2'd1 :
		((32'(axis_cnt_q) > MAX_AXES) ? 2'(MAX_AXES) : axis_cnt_q);
	assign n_cur = eff_size(size_q[ax_q]);
	assign mid   = SW'((lo_b_q + hi_b_q) >> 1);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// --- table RAM ---
	assign ram_we = accept && (op_t'(s_tdata[1:0]) == OP_LOAD) &&
		(32'(s_tdata[3:2]) < MAX_AXES) && (32'(s_tdata[11:4]) < MAX_COORDS);
	assign waddr = RW'(32'(s_tdata[3:2]) * MAX_COORDS + 32'(s_tdata[11:4]));
	assign wval  = CW'($signed(s_tdata[12 +: INW]));

	always_comb begin
		unique case (state_q)
			ST_LO_RD: raddr = RW'(32'(ax_q) * MAX_COORDS + 32'(lo_q[ax_q]));
			ST_LO_WAIT: raddr = RW'(32'(ax_q) * MAX_COORDS + 32'(up_q[ax_q]));
			default: raddr = RW'(32'(ax_q) * MAX_COORDS + 32'(mid[EW-1:0]));
		endcase
	end

	rgli_ram #(.WIDTH(CW), .DEPTH(DEP)) u_ram (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(wval),
		.raddr(raddr), .rdata(rdata)
	);

	// --- fraction ---
	assign span = {rdata[CW-1], rdata} - {clo_q[CW-1], clo_q};
	assign offs = {pt_q[ax_q][CW-1], pt_q[ax_q]} - {clo_q[CW-1], clo_q};
	assign div_start = (state_q == ST_UP_WAIT) && !span[CW] && (span != '0) &&
		!offs[CW] && (offs != '0) && ($signed(offs) < $signed(span));

	rgli_div #(.W(CW + 1)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(offs), .den(span),
		.done(div_done), .quot(div_q)
	);

	// --- sequencer ---
	logic srch_le;
	assign srch_le = (op_q == OP_INTERP) ?
		($signed(rdata) <= $signed(pt_q[ax_q])) :
		($signed(rdata) < $signed(pt_q[ax_q]));

	logic last_axis;
	assign last_axis = (ax_q == na_q - 2'd1);

	logic corner_hi;
	logic [1:0] corner_ax_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && (s_tdata[1:0] == OP_LOCATE ||
				s_tdata[1:0] == OP_INTERP)) state_d = ST_SRCH_RD;
			ST_SRCH_RD: state_d = (lo_b_q < hi_b_q) ? ST_SRCH_CMP : ST_LO_RD;
			ST_SRCH_CMP: state_d = ST_SRCH_RD;
			ST_LO_RD: state_d = (op_q == OP_INTERP) ? ST_LO_WAIT : ST_AXIS_END;
			ST_LO_WAIT: state_d = ST_UP_WAIT;
			ST_UP_WAIT: state_d = div_start ? ST_DIV : ST_AXIS_END;
			ST_DIV: if (div_done) state_d = ST_AXIS_END;
			ST_AXIS_END: state_d = last_axis ? ST_CORNER : ST_SRCH_RD;
			ST_CORNER: state_d = ST_CMUL1;
			ST_CMUL1: state_d = (corner_ax_q == na_q - 2'd1) ? ST_CMUL2 : ST_CMUL1;
			ST_CMUL2: state_d = ST_EMIT;
			ST_EMIT: if (!out_full_q) begin
				if (op_q == OP_LOCATE || corner_q == 4'((1 << na_q) - 1))
					state_d = ST_IDLE;
				else state_d = ST_CORNER;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign corner_hi = corner_q[corner_ax_q];

	logic [FRAC_W:0] wsel;
	assign wsel = corner_hi ? wu_q[corner_ax_q] : (ONE_Q16 - wu_q[corner_ax_q]);

	// exact running product; it stays below 2^33 until the last axis
	assign cprod = {{(ACC_W-2*FRAC_W-1){1'b0}}, acc_q[2*FRAC_W:0]} *
		{{(ACC_W-WGT_W){1'b0}}, wsel};

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q    <= s_tdata[1:0];
				pt_q[0] <= CW'($signed(s_tdata[44 +: INW]));
				pt_q[1] <= CW'($signed(s_tdata[76 +: INW]));
				pt_q[2] <= CW'($signed(s_tdata[108 +: INW]));
				na_q    <= na_in;
				ax_q    <= '0;
				f_q     <= IDX_W'(1);
				lo_b_q  <= '0;
				hi_b_q  <= eff_size(size_q[0]);
				corner_q <= '0;
			end
			ST_SRCH_RD: if (!(lo_b_q < hi_b_q)) begin
				up_q[ax_q] <= (lo_b_q > n_cur - 1'b1) ? EW'(n_cur - 1'b1) : EW'(lo_b_q);
				lo_q[ax_q] <= (n_cur == SW'(1)) ? '0 :
					((lo_b_q > n_cur - 1'b1) ? EW'(n_cur - SW'(2)) :
					((lo_b_q == '0) ? '0 : EW'(lo_b_q - 1'b1)));
			end
			ST_SRCH_CMP: begin
				if (srch_le) lo_b_q <= mid + 1'b1;
				else hi_b_q <= mid;
			end
			ST_LO_RD: wu_q[ax_q] <= '0;
			ST_LO_WAIT: clo_q <= rdata;
			ST_UP_WAIT: if (!div_start) wu_q[ax_q] <=
				(!span[CW] && span != '0 && !offs[CW] && offs != '0) ?
				ONE_Q16 : '0;
			ST_DIV: if (div_done) wu_q[ax_q] <= div_q;
			ST_AXIS_END: begin
				fac_q[ax_q] <= f_q;
				f_q    <= IDX_W'(f_q * IDX_W'(n_cur));
				ax_q   <= last_axis ? '0 : ax_q + 2'd1;
				lo_b_q <= '0;
				hi_b_q <= eff_size(size_q[ax_q + 2'd1]);
			end
			ST_CORNER: begin
				corner_ax_q <= '0;
				acc_q  <= ACC_W'(1);
				flat_q <= '0;
			end
			ST_CMUL1: begin
				acc_q  <= (corner_ax_q == '0) ? ACC_W'(wsel) : cprod;
				flat_q <= flat_q + IDX_W'(
					(corner_hi || op_q == OP_LOCATE ? up_q[corner_ax_q] : lo_q[corner_ax_q])
					* fac_q[corner_ax_q]);
				corner_ax_q <= corner_ax_q + 2'd1;
			end
			// single rounding of the product to Q1.16
			ST_CMUL2: acc_q <= (na_q == 2'd3) ?
				((acc_q + (ACC_W'(1) << (2*FRAC_W-1))) >> (2*FRAC_W)) :
				((na_q == 2'd2) ?
				((acc_q + (ACC_W'(1) << (FRAC_W-1))) >> FRAC_W) : acc_q);
			ST_EMIT: if (!out_full_q) corner_q <= corner_q + 4'd1;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_full_q <= 1'b0;
		else if (state_q == ST_EMIT && !out_full_q) out_full_q <= 1'b1;
		else if (m_tready) out_full_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && !out_full_q) begin
			o_flat_q <= flat_q;
			o_w_q    <= (op_q == OP_LOCATE) ? ONE_Q16 : WGT_W'(acc_q);
			o_last_q <= (op_q == OP_LOCATE) || (corner_q == 4'((1 << na_q) - 1));
		end
	end
	assign m_tvalid = out_full_q;
	assign m_tdata  = {7'd0, o_w_q, o_flat_q};
	assign m_tlast  = o_last_q;
endmodule
`default_nettype wire

FILE: src/rgli_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgli_checker
// Port-level checks for the grid locator, bound to the top level.
// ----------------------------------------------------------------------------
module rgli_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
	a_wmax: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40:24] <= 17'h10000)
		else $error("weight above one");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken mid query");
endmodule

bind rectilinear_grid_locate_interp rgli_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rectilinear grid locator: loads per-axis
// coordinate tables, runs locate and interpolation queries under random
// stalls on both streams, and compares every corner against a local model.
// ----------------------------------------------------------------------------
module tb;
	import rgli_pkg::*;

	typedef struct packed {
		logic [23:0] flat;
		logic [16:0] wgt;
		logic        lst;
	} corner_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [8:0]   cfg_data = '0;

	logic signed [31:0] grid_coord [3][256];
	int unsigned        grid_size [3];
	int unsigned        n_axes;
	corner_t            pending_corners [$];
	int                 n_fail = 0;
	int                 n_results = 0;
	int                 n_queries = 0;
	bit                 no_stall = 1'b0;

	rectilinear_grid_locate_interp u_top (.*);

	always #6 clk = ~clk;

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// output side: random stalls, compare each transfer with the oldest corner
	initial begin
		int gap;
		corner_t exp_c;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = no_stall ? 0 : $urandom_range(0, 8);
			m_tready = 1'b0;
			repeat (gap) @(negedge clk);
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			n_results++;
			if (pending_corners.size() == 0) begin
				$error("unexpected result flat=%0d", m_tdata[23:0]);
				n_fail++;
			end else begin
				exp_c = pending_corners.pop_front();
				if (m_tdata[23:0] !== exp_c.flat) begin
					$error("flat_index exp %0d got %0d", exp_c.flat, m_tdata[23:0]);
					n_fail++;
				end
				if (m_tdata[40:24] !== exp_c.wgt) begin
					$error("weight exp %0d got %0d", exp_c.wgt, m_tdata[40:24]);
					n_fail++;
				end
				if (m_tlast !== exp_c.lst) begin
					$error("last exp %0d got %0d", exp_c.lst, m_tlast);
					n_fail++;
				end
			end
		end
	end

	function automatic logic [16:0] cell_fraction(longint offs, longint span);
		longint q, r;
		if (span <= 0 || offs <= 0) return ONE_Q16 & 17'h0;
		if (offs >= span) return ONE_Q16;
		q = (offs <<< 16) / span;
		r = (offs <<< 16) % span;
		if (2 * r >= span) q++;
		return q[16:0];
	endfunction

	task automatic predict_corners(op_t op, logic signed [31:0] pt [3]);
		int unsigned idx, lo [3], up [3], fac [3], f, flat, nc;
		logic [16:0] wu [3], wl [3];
		logic [63:0] w;
		int unsigned shift;
		corner_t c;
		if (op == OP_LOCATE) begin
			flat = 0;
			f = 1;
			for (int k = 0; k < n_axes; k++) begin
				idx = 0;
				while (idx < grid_size[k] && grid_coord[k][idx] < pt[k]) idx++;
				if (idx > grid_size[k] - 1) idx = grid_size[k] - 1;
				flat = (flat + idx * f) & 24'hFFFFFF;
				f = (f * grid_size[k]) & 24'hFFFFFF;
			end
			c.flat = flat;
			c.wgt = ONE_Q16;
			c.lst = 1'b1;
			pending_corners.push_back(c);
			return;
		end
		f = 1;
		for (int k = 0; k < n_axes; k++) begin
			idx = 0;
			while (idx < grid_size[k] && grid_coord[k][idx] <= pt[k]) idx++;
			if (idx > grid_size[k] - 1) idx = grid_size[k] - 1;
			up[k] = idx;
			lo[k] = idx > 0 ? idx - 1 : 0;
			wu[k] = cell_fraction(longint'(pt[k]) - longint'(grid_coord[k][lo[k]]),
				longint'(grid_coord[k][up[k]]) - longint'(grid_coord[k][lo[k]]));
			wl[k] = ONE_Q16 - wu[k];
			fac[k] = f;
			f = (f * grid_size[k]) & 24'hFFFFFF;
		end
		nc = 1 << n_axes;
		shift = 16 * (n_axes - 1);
		for (int unsigned cn = 0; cn < nc; cn++) begin
			flat = 0;
			w = 1;
			for (int k = 0; k < n_axes; k++) begin
				flat = (flat + (cn[k] ? up[k] : lo[k]) * fac[k]) & 24'hFFFFFF;
				w = w * (cn[k] ? wu[k] : wl[k]);
			end
			if (shift > 0) w = (w + (64'd1 << (shift - 1))) >> shift;
			c.flat = flat;
			c.wgt = w[16:0];
			c.lst = (cn == nc - 1);
			pending_corners.push_back(c);
		end
	endtask

	// one input transfer; the model is updated at acceptance
	task automatic send_item(op_t op, logic [1:0] ax, logic [7:0] ei,
			logic signed [31:0] cv, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		logic signed [31:0] pt [3];
		repeat ($urandom_range(0, 8)) @(negedge clk);
		s_tdata = {4'h0, pz, py, px, cv, ei, ax, op};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		if (op == OP_LOAD) begin
			if (ax < 3) grid_coord[ax][ei] = cv;
		end else if (op != OP_NONE) begin
			predict_corners(op, pt);
			n_queries++;
		end
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tdata = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
	endtask

	task automatic drain_results();
		while (pending_corners.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_reg(reg_t r, logic [8:0] v);
		cfg_index = r;
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			REG_AXIS_COUNT: n_axes = v[1:0] == 0 ? 1 : (v[1:0] > 3 ? 3 : v[1:0]);
			default: grid_size[r - 1] = v == 0 ? 1 : (v > 256 ? 256 : v);
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// non-decreasing table on each axis (repeats when dup is set), random step
	// sizes; n0 entries on axis zero and n12 on the other two
	task automatic load_tables(int unsigned step_max, bit dup, int unsigned n0,
			int unsigned n12);
		logic signed [31:0] v;
		int unsigned cnt;
		for (int a = 0; a < 3; a++) begin
			v = -$signed(32'($urandom_range(0, step_max * 128)));
			cnt = (a == 0) ? n0 : n12;
			for (int i = 0; i < cnt; i++) begin
				send_item(OP_LOAD, 2'(a), 8'(i), v, $urandom, $urandom, $urandom);
				if (!(dup && $urandom_range(0, 3) == 0))
					v = v + $urandom_range(1, step_max);
			end
		end
	endtask

	task automatic set_grid(int unsigned na, int unsigned s0, int unsigned s1,
			int unsigned s2);
		drain_results();
		write_reg(REG_AXIS_COUNT, 9'(na));
		write_reg(REG_SIZE0, 9'(s0));
		write_reg(REG_SIZE1, 9'(s1));
		write_reg(REG_SIZE2, 9'(s2));
	endtask

	function automatic logic signed [31:0] pick_point(int a);
		int unsigned i;
		i = $urandom_range(0, grid_size[a] - 1);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return grid_coord[a][i];
			2: return grid_coord[a][0] - $urandom_range(0, 300);
			3: return grid_coord[a][grid_size[a] - 1] + $urandom_range(0, 300);
			default: return grid_coord[a][i] + $urandom_range(0, 65536);
		endcase
	endfunction

	task automatic random_query();
		op_t op;
		op = $urandom_range(0, 9) == 0 ? OP_NONE :
			($urandom_range(0, 1) ? OP_LOCATE : OP_INTERP);
		send_item(op, 2'($urandom), 8'($urandom), $urandom,
			pick_point(0), pick_point(1), pick_point(2));
	endtask

	task automatic test_extremes();
		load_tables(70000, 1'b0, 256, 16);
		set_grid(1, 256, 1, 1);
		send_item(OP_LOCATE, 0, 0, 0, 32'sh8000_0000, 0, 0);
		send_item(OP_LOCATE, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0);
		send_item(OP_INTERP, 0, 0, 0, 32'sh8000_0000, 0, 0);
		send_item(OP_INTERP, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0);
		send_item(OP_INTERP, 0, 0, 0, grid_coord[0][7], 0, 0);
		send_item(OP_NONE, 3, 8'hFF, 32'hFFFF_FFFF, '1, '1, '1);
		send_item(OP_LOAD, 3, 8'hFF, 32'h1234_5678, 0, 0, 0);
		set_grid(0, 0, 0, 0);
		send_item(OP_INTERP, 0, 0, 0, 0, 0, 0);
		send_item(OP_LOCATE, 0, 0, 0, '1, 0, 0);
		set_grid(3, 256, 16, 16);
		send_item(OP_INTERP, 0, 0, 0, grid_coord[0][255], grid_coord[1][0],
			grid_coord[2][10] + 5);
		send_item(OP_LOCATE, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_item(OP_INTERP, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		set_grid(2, 511, 2, 1);
		send_item(OP_INTERP, 0, 0, 0, pick_point(0), pick_point(1), 0);
	endtask

	task automatic test_zero_span();
		load_tables(3, 1'b1, 8, 8);
		set_grid(3, 8, 8, 8);
		repeat (15) random_query();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 4; ph++) begin
			set_grid($urandom_range(1, 3), $urandom_range(1, 256),
				$urandom_range(1, 16), $urandom_range(1, 16));
			no_stall = (ph == 2);
			repeat (20) random_query();
		end
		no_stall = 1'b0;
	endtask

	task automatic test_flush_pause();
		set_grid(3, 2, 3, 2);
		repeat (5) random_query();
		drain_results();
		repeat (5) random_query();
	endtask

	initial begin
		grid_size = '{1, 1, 1};
		n_axes = 3;
		s_tdata = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_random();
		test_flush_pause();
		test_zero_span();
		drain_results();
		$display("Covered %0d queries with %0d results, table loads, register sweeps.",
			n_queries, n_results);
		if (n_fail == 0 && pending_corners.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
